// File: src/mcs_pkg.sv
// Shared types, widths and constants of the mask centroid steering block.
`default_nettype none
package mcs_pkg;

    localparam int MAX_DIM_DEF = 2048;

    localparam int CFG_DIM_W  = 12;
    localparam int GAIN_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int MASK_W     = 8;

    localparam int CENT_W  = 11;
    localparam int COUNT_W = 23;
    localparam int SPEED_W = 27;
    localparam int HALF_W  = 12;
    localparam int DIFF_W  = 13;
    localparam int PROD_W  = DIFF_W + GAIN_W + 1;

    localparam logic [MASK_W-1:0]    MASK_SET  = 8'hFF;
    localparam logic [CENT_W-1:0]    CENT_MAX  = '1;
    localparam logic [COUNT_W-1:0]   COUNT_MAX = '1;

    localparam logic [CFG_DIM_W-1:0] WIDTH_RST   = 12'd960;
    localparam logic [CFG_DIM_W-1:0] HEIGHT_RST  = 12'd540;
    localparam logic [GAIN_W-1:0]    FWD_GAIN_RST  = 16'd131;
    localparam logic [GAIN_W-1:0]    TURN_GAIN_RST = 16'd197;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH,
        REG_FRAME_HEIGHT,
        REG_FORWARD_GAIN,
        REG_TURN_GAIN
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_ACCUM,
        ST_DIV_X,
        ST_DIV_Y,
        ST_MUL_F,
        ST_MUL_T,
        ST_FINISH
    } seq_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

    typedef struct packed {
        logic              en;
        logic [HALF_W-1:0] half;
        logic [CENT_W-1:0] cent;
        logic [GAIN_W-1:0] gain;
    } mul_req_t;

endpackage
`default_nettype wire

// File: src/mcs_divider.sv
// Shared restoring divider, one quotient bit per cycle.
`default_nettype none
module mcs_divider import mcs_pkg::*; #(
    parameter int CW = 11
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [3*CW-1:0]   dividend,
    input  wire logic [2*CW:0]     divisor,
    output div_status_t            status,
    output logic      [CW-1:0]     quotient
);

    localparam int SW  = 3 * CW;
    localparam int NW  = 2 * CW + 1;
    localparam int SCW = $clog2(CW);

    logic [NW-1:0]  rem_reg, rem_next;
    logic [CW-1:0]  lo_reg, lo_next;
    logic [NW-1:0]  div_reg;
    logic [SCW-1:0] step_reg, step_next;
    logic           busy_reg, busy_next;
    logic           done_reg, done_next;

    logic [NW:0] trial;
    logic [NW:0] trial_diff;
    logic        fits;

    // The quotient is known to stay below 2**CW, so the upper bits of the
    // dividend start out below the divisor and only CW steps are needed.
    always_comb
    begin
        trial      = {rem_reg, lo_reg[CW-1]};
        fits       = trial >= {1'b0, div_reg};
        trial_diff = trial - {1'b0, div_reg};
        rem_next   = fits ? trial_diff[NW-1:0] : trial[NW-1:0];
        lo_next    = {lo_reg[CW-2:0], fits};
        step_next  = step_reg + 1'b1;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
        end
        else if (busy_reg && step_reg == SCW'(CW - 1))
        begin
            busy_next = 1'b0;
            done_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            if (start || busy_reg)
            begin
                step_reg <= step_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= NW'(dividend[SW-1:CW]);
            lo_reg  <= dividend[CW-1:0];
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            lo_reg  <= lo_next;
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = lo_reg;

endmodule
`default_nettype wire

// File: src/mcs_speed_mul.sv
// Shared signed multiplier for the steering speeds, with saturation.
`default_nettype none
module mcs_speed_mul import mcs_pkg::*; (
    input  wire logic               clk,
    input  wire mul_req_t           req,
    output logic [SPEED_W-1:0]      speed
);

    localparam logic signed [PROD_W-1:0] SAT_HI = PROD_W'((1 <<< (SPEED_W - 1)) - 1);
    localparam logic signed [PROD_W-1:0] SAT_LO = -SAT_HI - PROD_W'(1);

    logic signed [DIFF_W-1:0] diff;
    logic signed [GAIN_W:0]   gain_s;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] prod_sat;

    assign diff   = $signed({1'b0, req.half}) - $signed({2'b00, req.cent});
    assign gain_s = $signed({1'b0, req.gain});

    always_ff @(posedge clk)
    begin
        if (req.en)
        begin
            prod_reg <= diff * gain_s;
        end
    end

    always_comb
    begin
        prod_sat = prod_reg;
        if (prod_reg > SAT_HI)
        begin
            prod_sat = SAT_HI;
        end
        else if (prod_reg < SAT_LO)
        begin
            prod_sat = SAT_LO;
        end
    end

    assign speed = prod_sat[SPEED_W-1:0];

endmodule
`default_nettype wire

// File: src/mask_centroid_steering.sv
// Top level of the mask centroid steering block: pixel accumulation and result sequencer.
//
//  Channel  | Signals                                       | Moves
//  ---------+-----------------------------------------------+------------------------------
//  input    | in_valid, in_ready, mask_byte                 | one mask pixel per word
//  output   | out_valid, out_ready, target_found ...        | one result word per frame
//  config   | cfg_we, cfg_index, cfg_data                   | one register write per cycle
//
// Pixels are taken at one per cycle while in_ready is high. A frame with set
// pixels ends with a stretch in which in_ready is low: the shared restoring
// divider makes both centroids one bit a cycle, then the shared multiplier makes
// both speeds. An empty frame gives its result at once.
// The last pixel of a frame waits while the previous result word is not yet taken.
// Reset restores the register defaults and clears the counters and sums.
`default_nettype none
module mask_centroid_steering import mcs_pkg::*; #(
    parameter int MAX_DIM = MAX_DIM_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic [MASK_W-1:0]        mask_byte,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic                          target_found,
    output logic [CENT_W-1:0]             centroid_x,
    output logic [CENT_W-1:0]             centroid_y,
    output logic [COUNT_W-1:0]            set_pixel_count,
    output logic signed [SPEED_W-1:0]     forward_speed,
    output logic signed [SPEED_W-1:0]     turn_speed,
    input  wire logic                     cfg_we,
    input  wire logic [CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [CFG_DATA_W-1:0]    cfg_data
);

    // Counter width, clamped size width, sum width and count width.
    localparam int CW = $clog2(MAX_DIM);
    localparam int DW = $clog2(MAX_DIM + 1);
    localparam int SW = 3 * CW;
    localparam int NW = 2 * CW + 1;
    localparam logic [CFG_DIM_W:0] DIM_LIMIT = (CFG_DIM_W + 1)'(MAX_DIM);

    // Configuration registers.
    logic [CFG_DIM_W-1:0] frame_width_reg;
    logic [CFG_DIM_W-1:0] frame_height_reg;
    logic [GAIN_W-1:0]    forward_gain_reg;
    logic [GAIN_W-1:0]    turn_gain_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= WIDTH_RST;
            frame_height_reg <= HEIGHT_RST;
            forward_gain_reg <= FWD_GAIN_RST;
            turn_gain_reg    <= TURN_GAIN_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[CFG_DIM_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data[CFG_DIM_W-1:0];
                REG_FORWARD_GAIN: forward_gain_reg <= cfg_data[GAIN_W-1:0];
                REG_TURN_GAIN:    turn_gain_reg    <= cfg_data[GAIN_W-1:0];
                default:          ;
            endcase
        end
    end

    // A size of zero counts as one, and a size above MAX_DIM as MAX_DIM.
    logic [CFG_DIM_W:0] width_wide, height_wide;
    logic [DW-1:0]      width_c, height_c;
    logic [HALF_W-1:0]  half_w, half_h;

    always_comb
    begin
        width_wide = {1'b0, frame_width_reg};
        if (frame_width_reg == '0)
        begin
            width_wide = (CFG_DIM_W + 1)'(1);
        end
        else if (width_wide > DIM_LIMIT)
        begin
            width_wide = DIM_LIMIT;
        end
        height_wide = {1'b0, frame_height_reg};
        if (frame_height_reg == '0)
        begin
            height_wide = (CFG_DIM_W + 1)'(1);
        end
        else if (height_wide > DIM_LIMIT)
        begin
            height_wide = DIM_LIMIT;
        end
    end

    assign width_c  = DW'(width_wide);
    assign height_c = DW'(height_wide);
    assign half_w   = HALF_W'(width_c >> 1);
    assign half_h   = HALF_W'(height_c >> 1);

    // Raster position and running sums.
    logic [CW-1:0] col_reg, row_reg;
    logic [SW-1:0] col_sum_reg, row_sum_reg;
    logic [NW-1:0] count_reg;

    logic [DW:0]   col_inc, row_inc;
    logic          col_last, row_last, frame_end;
    logic          px_set;
    logic [SW-1:0] col_sum_add, row_sum_add;
    logic [NW-1:0] count_add;
    logic          in_acc;

    assign col_inc   = (DW + 1)'(col_reg) + 1'b1;
    assign row_inc   = (DW + 1)'(row_reg) + 1'b1;
    assign col_last  = col_inc >= {1'b0, width_c};
    assign row_last  = row_inc >= {1'b0, height_c};
    assign frame_end = col_last && row_last;

    // Only a byte of exactly 255 counts as a set pixel.
    assign px_set      = mask_byte == MASK_SET;
    assign col_sum_add = px_set ? col_sum_reg + SW'(col_reg) : col_sum_reg;
    assign row_sum_add = px_set ? row_sum_reg + SW'(row_reg) : row_sum_reg;
    assign count_add   = px_set ? count_reg + 1'b1 : count_reg;

    seq_state_t state_reg, state_next;

    // The last pixel of a frame is held off while the previous result waits,
    // so a finished result is never overwritten.
    assign in_ready = (state_reg == ST_ACCUM) && !(frame_end && out_valid);
    assign in_acc   = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= '0;
            row_reg     <= '0;
            col_sum_reg <= '0;
            row_sum_reg <= '0;
            count_reg   <= '0;
        end
        else if (in_acc)
        begin
            if (frame_end)
            begin
                col_sum_reg <= '0;
                row_sum_reg <= '0;
                count_reg   <= '0;
            end
            else
            begin
                col_sum_reg <= col_sum_add;
                row_sum_reg <= row_sum_add;
                count_reg   <= count_add;
            end
            if (col_last)
            begin
                col_reg <= '0;
                row_reg <= row_last ? '0 : row_inc[CW-1:0];
            end
            else
            begin
                col_reg <= col_inc[CW-1:0];
            end
        end
    end

    // Shared divider and multiplier.
    div_status_t   div_status;
    logic          div_start;
    logic [SW-1:0] div_dividend;
    logic [NW-1:0] div_divisor;
    logic [CW-1:0] div_quotient;
    mul_req_t      mul_req;
    logic [SPEED_W-1:0] mul_speed;

    mcs_divider #(
        .CW (CW)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .status   (div_status),
        .quotient (div_quotient)
    );

    mcs_speed_mul u_speed_mul (
        .clk   (clk),
        .req   (mul_req),
        .speed (mul_speed)
    );

    // Frame totals held while the result is worked out.
    logic [SW-1:0] row_hold_reg;
    logic [NW-1:0] count_hold_reg;

    // Result word registers.
    logic                    out_valid_reg;
    logic                    target_found_reg;
    logic [CENT_W-1:0]       centroid_x_reg, centroid_y_reg;
    logic [COUNT_W-1:0]      set_pixel_count_reg;
    logic [SPEED_W-1:0]      forward_speed_reg, turn_speed_reg;

    // Sequencer controls.
    logic load_hold, load_cx, load_cy, load_fwd, load_out, zero_result;

    always_comb
    begin
        state_next   = state_reg;
        div_start    = 1'b0;
        div_dividend = col_sum_add;
        div_divisor  = count_hold_reg;
        load_hold    = 1'b0;
        load_cx      = 1'b0;
        load_cy      = 1'b0;
        load_fwd     = 1'b0;
        load_out     = 1'b0;
        zero_result  = 1'b0;
        mul_req.en   = 1'b0;
        mul_req.half = half_h;
        mul_req.cent = centroid_y_reg;
        mul_req.gain = forward_gain_reg;
        case (state_reg)
            ST_ACCUM:
            begin
                div_divisor = count_add;
                if (in_acc && frame_end)
                begin
                    if (count_add != '0)
                    begin
                        div_start  = 1'b1;
                        load_hold  = 1'b1;
                        state_next = ST_DIV_X;
                    end
                    else
                    begin
                        zero_result = 1'b1;
                    end
                end
            end
            ST_DIV_X:
            begin
                div_dividend = row_hold_reg;
                if (div_status.done)
                begin
                    load_cx    = 1'b1;
                    div_start  = 1'b1;
                    state_next = ST_DIV_Y;
                end
            end
            ST_DIV_Y:
            begin
                if (div_status.done)
                begin
                    load_cy    = 1'b1;
                    state_next = ST_MUL_F;
                end
            end
            ST_MUL_F:
            begin
                mul_req.en = 1'b1;
                state_next = ST_MUL_T;
            end
            ST_MUL_T:
            begin
                load_fwd     = 1'b1;
                mul_req.en   = 1'b1;
                mul_req.half = half_w;
                mul_req.cent = centroid_x_reg;
                mul_req.gain = turn_gain_reg;
                state_next   = ST_FINISH;
            end
            ST_FINISH:
            begin
                load_out   = 1'b1;
                state_next = ST_ACCUM;
            end
            default:
            begin
                state_next = ST_ACCUM;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_ACCUM;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out || zero_result)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Saturation of the centroid and of the count; it only bites when MAX_DIM
    // is above its default.
    logic [CFG_DIM_W-1:0] quo_ext;
    logic [CENT_W-1:0]    cent_sat;
    logic [31:0]          count_ext;
    logic [COUNT_W-1:0]   count_sat;

    assign quo_ext   = CFG_DIM_W'(div_quotient);
    assign cent_sat  = (quo_ext > CFG_DIM_W'(CENT_MAX)) ? CENT_MAX : quo_ext[CENT_W-1:0];
    assign count_ext = 32'(count_hold_reg);
    assign count_sat = (count_ext > 32'(COUNT_MAX)) ? COUNT_MAX : count_ext[COUNT_W-1:0];

    // The result registers are free while a frame is worked out, so the
    // sequencer writes each field as it becomes known.
    always_ff @(posedge clk)
    begin
        if (load_hold)
        begin
            row_hold_reg   <= row_sum_add;
            count_hold_reg <= count_add;
        end
        if (zero_result)
        begin
            target_found_reg    <= 1'b0;
            centroid_x_reg      <= '0;
            centroid_y_reg      <= '0;
            set_pixel_count_reg <= '0;
            forward_speed_reg   <= '0;
            turn_speed_reg      <= '0;
        end
        else
        begin
            if (load_cx)
            begin
                centroid_x_reg <= cent_sat;
            end
            if (load_cy)
            begin
                centroid_y_reg <= cent_sat;
            end
            if (load_fwd)
            begin
                forward_speed_reg <= mul_speed;
            end
            if (load_out)
            begin
                target_found_reg    <= 1'b1;
                set_pixel_count_reg <= count_sat;
                turn_speed_reg      <= mul_speed;
            end
        end
    end

    assign out_valid       = out_valid_reg;
    assign target_found    = target_found_reg;
    assign centroid_x      = centroid_x_reg;
    assign centroid_y      = centroid_y_reg;
    assign set_pixel_count = set_pixel_count_reg;
    assign forward_speed   = forward_speed_reg;
    assign turn_speed      = turn_speed_reg;

endmodule
`default_nettype wire

// File: src/mcs_checker.sv
// Port-level assertions for the mask centroid steering block, with their bind.
`default_nettype none
module mcs_checker import mcs_pkg::*; (
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   out_valid,
    input wire logic                   out_ready,
    input wire logic                   target_found,
    input wire logic [CENT_W-1:0]      centroid_x,
    input wire logic [CENT_W-1:0]      centroid_y,
    input wire logic [COUNT_W-1:0]     set_pixel_count,
    input wire logic [SPEED_W-1:0]     forward_speed,
    input wire logic [SPEED_W-1:0]     turn_speed
);

    // A waiting result word holds until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(centroid_x) && $stable(centroid_y)
            && $stable(set_pixel_count) && $stable(forward_speed) && $stable(turn_speed)
            && $stable(target_found))
        else $error("result word changed while stalled");

    // An empty frame reports all fields as zero.
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !target_found |-> centroid_x == '0 && centroid_y == '0
            && set_pixel_count == '0 && forward_speed == '0 && turn_speed == '0)
        else $error("empty frame with nonzero fields");

    // A found target always comes with a nonzero count.
    a_found_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && target_found |-> set_pixel_count != '0)
        else $error("target found with zero count");

    // A new result needs at least one more pixel, so results never follow back to back.
    a_result_gap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready |=> !out_valid)
        else $error("result word repeated or invented");

endmodule

bind mask_centroid_steering mcs_checker u_mcs_checker (.*);
`default_nettype wire
